// ----- rtl/osd_pkg.sv -----
// Types, codes and helpers shared by the ordered-stage task dispatcher.
package osd_pkg;

  // Request opcodes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_ABORT   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ITERATIONS = 2'd0;
  localparam logic [1:0] CFG_WORKERS    = 2'd1;
  localparam logic [1:0] CFG_SLOTS      = 2'd2;

  typedef enum logic [2:0] {
    PH_READY_START  = 3'd0,
    PH_STARTING     = 3'd1,
    PH_READY_ORDER  = 3'd2,
    PH_ORDERING     = 3'd3,
    PH_READY_FINISH = 3'd4,
    PH_FINISHING    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    G_NONE    = 3'd0,
    G_START   = 3'd1,
    G_ORDERED = 3'd2,
    G_FINISH  = 3'd3,
    G_WAIT    = 3'd4,
    G_REJECT  = 3'd5
  } grant_t;

  // Finishing wraps round to ready-to-start; unused codes fall back there too.
  function automatic phase_t phase_inc(input phase_t p);
    phase_t r;
    case (p)
      PH_READY_START:  r = PH_STARTING;
      PH_STARTING:     r = PH_READY_ORDER;
      PH_READY_ORDER:  r = PH_ORDERING;
      PH_ORDERING:     r = PH_READY_FINISH;
      PH_READY_FINISH: r = PH_FINISHING;
      default:         r = PH_READY_START;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ordered_stage_task_dispatcher_top.sv -----
// A request is taken into an input register and its result is then written to the result
// register; one request per cycle is sustained while neither busy nor res_stall holds it.
// After any configuration write a bit-serial remainder unit rebuilds the three queue
// residues (count mod slots), one count bit a cycle, with requests stalled until all bits are done.
// Reset: synchronous, active high; clears slot phases, held slots, counts, pointers,
// the ordered-phase holder and the configuration (iterations 1, workers 2, slots 3).
module ordered_stage_task_dispatcher_top #(
  parameter int MAX_SLOTS   = 32,
  parameter int MAX_WORKERS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [4:0]  worker,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  grant,
  output logic [4:0]  slot,
  output logic [31:0] iteration,
  output logic [31:0] ordered_done,
  output logic        finishes_settled
);
  import osd_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NS_W   = $clog2(MAX_SLOTS + 1);
  localparam int WK_W   = $clog2(MAX_WORKERS);
  localparam int BI_W   = $clog2(COUNT_BITS);

  // configuration
  logic [COUNT_BITS-1:0] iter_cfg;
  logic [4:0]            worker_cfg;
  logic [5:0]            slots_cfg;
  logic [NS_W-1:0]       eff_slots;

  // request input register
  logic       req_full;
  logic       req_opcode;
  logic [4:0] req_worker;
  logic       step;

  // dispatcher state
  phase_t                phase      [MAX_SLOTS];
  logic [COUNT_BITS-1:0] slot_iter  [MAX_SLOTS];
  logic                  hold_valid [MAX_WORKERS];
  logic [SLOT_W-1:0]     hold_slot  [MAX_WORKERS];
  logic [COUNT_BITS-1:0] started_cnt, ordered_cnt, finished_cnt;
  logic [SLOT_W-1:0]     start_ptr, order_ptr, finish_ptr;
  logic [SLOT_W-1:0]     start_res, order_res, finish_res;
  logic                  holder_set, holder_dead;
  logic [WK_W-1:0]       holder_id;

  // residue rebuild
  logic                  busy;
  logic [BI_W-1:0]       bit_idx;
  logic [NS_W-1:0]       div_rem    [3];
  logic [NS_W-1:0]       div_rem_next [3];
  logic [COUNT_BITS-1:0] div_src    [3];
  logic [NS_W:0]         div_trial  [3];

  // step logic
  logic [WK_W-1:0]       w_idx;
  logic                  reject, do_req, do_abort;
  logic                  held_ok;
  logic [SLOT_W-1:0]     held;
  logic                  holder_clear;
  logic                  can_order, can_finish, can_start;
  phase_t                ph_ret     [MAX_SLOTS];
  phase_t                phase_next [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  finishing_vec;
  grant_t                grant_next;
  logic [SLOT_W-1:0]     gslot;
  logic                  has_slot;
  logic [COUNT_BITS-1:0] iter_next;
  logic                  iter_we;
  logic [COUNT_BITS-1:0] started_cnt_next, ordered_cnt_next, finished_cnt_next;
  logic [SLOT_W-1:0]     start_ptr_next, order_ptr_next, finish_ptr_next;
  logic [SLOT_W-1:0]     start_res_next, order_res_next, finish_res_next;
  logic                  holder_set_next, holder_dead_next;
  logic [WK_W-1:0]       holder_id_next;
  logic                  settled_next;

  function automatic logic [SLOT_W-1:0] res_adv(input logic [SLOT_W-1:0] r,
                                                input logic [NS_W-1:0] ns);
    logic [NS_W-1:0] inc;
    inc = NS_W'(r) + NS_W'(1);
    return (inc == ns) ? '0 : SLOT_W'(inc);
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    if (slots_cfg == 6'd0) begin
      eff_slots = NS_W'(1);
    end else if (32'(slots_cfg) > MAX_SLOTS) begin
      eff_slots = NS_W'(MAX_SLOTS);
    end else begin
      eff_slots = NS_W'(slots_cfg);
    end
  end

  // handshake: one request in flight in the input register, result register in front
  assign step      = req_full && !busy && (!res_valid || !res_stall);
  assign req_stall = req_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_full <= 1'b1;
    end else if (step) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_opcode <= opcode;
      req_worker <= worker;
    end
  end

  // bit-serial remainder of each queue count by the slot count
  always_comb begin
    div_src[0] = started_cnt;
    div_src[1] = ordered_cnt;
    div_src[2] = finished_cnt;
    for (int q = 0; q < 3; q++) begin
      div_trial[q] = {div_rem[q], div_src[q][bit_idx]};
      if (div_trial[q] >= {1'b0, eff_slots}) begin
        div_trial[q] = div_trial[q] - {1'b0, eff_slots};
      end
      div_rem_next[q] = div_trial[q][NS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_idx <= '0;
    end else if (cfg_valid && cfg_ready) begin
      busy    <= 1'b1;
      bit_idx <= BI_W'(COUNT_BITS - 1);
    end else if (busy) begin
      if (bit_idx == '0) begin
        busy <= 1'b0;
      end else begin
        bit_idx <= bit_idx - BI_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < 3; q++) begin
      if (cfg_valid && cfg_ready) begin
        div_rem[q] <= '0;
      end else if (busy) begin
        div_rem[q] <= div_rem_next[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cfg   <= COUNT_BITS'(1);
      worker_cfg <= 5'd2;
      slots_cfg  <= 6'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ITERATIONS: iter_cfg   <= COUNT_BITS'(cfg_data);
        CFG_WORKERS:    worker_cfg <= cfg_data[4:0];
        CFG_SLOTS:      slots_cfg  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // one request: retire the held slot, then grant by priority (ordered, finish, start); an abort exhausts all counts
  always_comb begin
    w_idx        = WK_W'(req_worker);
    reject       = (req_worker >= worker_cfg) || (32'(req_worker) >= MAX_WORKERS);
    do_abort     = step && (req_opcode == OP_ABORT);
    do_req       = step && (req_opcode == OP_REQUEST) && !reject;
    held_ok      = hold_valid[w_idx];
    held         = hold_slot[w_idx];
    holder_clear = holder_set && (holder_id == w_idx);

    for (int s = 0; s < MAX_SLOTS; s++) begin
      ph_ret[s] = phase[s];
      if (do_req && held_ok && (held == SLOT_W'(s))) begin
        ph_ret[s] = phase_inc(phase[s]);
      end
    end

    can_order  = !(holder_set && !holder_clear) && !holder_dead &&
                 (ordered_cnt < iter_cfg) && (ph_ret[order_ptr] == PH_READY_ORDER);
    can_finish = (finished_cnt < iter_cfg) && (ph_ret[finish_ptr] == PH_READY_FINISH);
    can_start  = (started_cnt < iter_cfg) && (ph_ret[start_ptr] == PH_READY_START);

    phase_next        = ph_ret;
    grant_next        = G_REJECT;
    gslot             = '0;
    has_slot          = 1'b0;
    iter_next         = '0;
    iter_we           = 1'b0;
    started_cnt_next  = started_cnt;
    ordered_cnt_next  = ordered_cnt;
    finished_cnt_next = finished_cnt;
    start_ptr_next    = start_ptr;
    order_ptr_next    = order_ptr;
    finish_ptr_next   = finish_ptr;
    start_res_next    = start_res;
    order_res_next    = order_res;
    finish_res_next   = finish_res;
    holder_set_next   = holder_set;
    holder_dead_next  = holder_dead;
    holder_id_next    = holder_id;

    if (do_abort) begin
      started_cnt_next  = iter_cfg;
      ordered_cnt_next  = iter_cfg;
      finished_cnt_next = iter_cfg;
      holder_set_next   = 1'b0;
      holder_dead_next  = 1'b1;
    end else if (do_req) begin
      if (holder_clear) begin
        holder_set_next = 1'b0;
      end
      if (can_order) begin
        grant_next       = G_ORDERED;
        gslot            = order_ptr;
        has_slot         = 1'b1;
        holder_set_next  = 1'b1;
        holder_id_next   = w_idx;
        ordered_cnt_next = ordered_cnt + COUNT_BITS'(1);
        order_res_next   = res_adv(order_res, eff_slots);
        order_ptr_next   = order_res_next;
        phase_next[gslot] = phase_inc(ph_ret[gslot]);
        iter_next        = slot_iter[gslot];
      end else if (can_finish) begin
        grant_next        = G_FINISH;
        gslot             = finish_ptr;
        has_slot          = 1'b1;
        finished_cnt_next = finished_cnt + COUNT_BITS'(1);
        finish_res_next   = res_adv(finish_res, eff_slots);
        finish_ptr_next   = finish_res_next;
        phase_next[gslot] = phase_inc(ph_ret[gslot]);
        iter_next         = slot_iter[gslot];
      end else if (can_start) begin
        grant_next        = G_START;
        gslot             = start_ptr;
        has_slot          = 1'b1;
        iter_we           = 1'b1;
        started_cnt_next  = started_cnt + COUNT_BITS'(1);
        start_res_next    = res_adv(start_res, eff_slots);
        start_ptr_next    = start_res_next;
        phase_next[gslot] = PH_STARTING;
        iter_next         = started_cnt;
      end else if (finished_cnt < iter_cfg) begin
        grant_next = G_WAIT;
      end else begin
        grant_next = G_NONE;
      end
    end

    // settled flag is taken from the state after this request
    for (int s = 0; s < MAX_SLOTS; s++) begin
      finishing_vec[s] = (NS_W'(s) < eff_slots) && (phase_next[s] == PH_FINISHING);
    end
    settled_next = (ordered_cnt_next != '0) &&
                   (finished_cnt_next == ordered_cnt_next - COUNT_BITS'(1)) &&
                   !(|finishing_vec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        phase[s] <= PH_READY_START;
      end
      for (int i = 0; i < MAX_WORKERS; i++) begin
        hold_valid[i] <= 1'b0;
      end
      started_cnt  <= '0;
      ordered_cnt  <= '0;
      finished_cnt <= '0;
      start_ptr    <= '0;
      order_ptr    <= '0;
      finish_ptr   <= '0;
      start_res    <= '0;
      order_res    <= '0;
      finish_res   <= '0;
      holder_set   <= 1'b0;
      holder_dead  <= 1'b0;
      holder_id    <= '0;
    end else if (busy && (bit_idx == '0)) begin
      start_res  <= SLOT_W'(div_rem_next[0]);
      order_res  <= SLOT_W'(div_rem_next[1]);
      finish_res <= SLOT_W'(div_rem_next[2]);
    end else if (step) begin
      phase        <= phase_next;
      started_cnt  <= started_cnt_next;
      ordered_cnt  <= ordered_cnt_next;
      finished_cnt <= finished_cnt_next;
      start_ptr    <= start_ptr_next;
      order_ptr    <= order_ptr_next;
      finish_ptr   <= finish_ptr_next;
      start_res    <= start_res_next;
      order_res    <= order_res_next;
      finish_res   <= finish_res_next;
      holder_set   <= holder_set_next;
      holder_dead  <= holder_dead_next;
      holder_id    <= holder_id_next;
      if (do_req) begin
        hold_valid[w_idx] <= has_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_req) begin
      hold_slot[w_idx] <= gslot;
    end
    if (do_req && iter_we) begin
      slot_iter[gslot] <= started_cnt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= step || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      grant            <= grant_next;
      slot             <= 5'(gslot);
      iteration        <= 32'(iter_next);
      ordered_done     <= 32'(ordered_cnt_next);
      finishes_settled <= settled_next;
    end
  end

endmodule

// ----- sim/tb_ordered_stage_task_dispatcher_top.sv -----
// Testbench for the ordered-stage task dispatcher: directed table, then randomised runs.
`timescale 1ns / 1ps

module tb_ordered_stage_task_dispatcher_top;
  import osd_pkg::*;

  localparam int MAX_SLOTS   = 32;
  localparam int MAX_WORKERS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int PHASES      = 12;
  localparam int PHASE_CAP   = 50;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [5:0] HOLD_NONE  = 6'd32;
  localparam logic [5:0] OWNER_NONE = 6'd16;
  localparam logic [5:0] OWNER_DEAD = 6'd17;

  typedef struct packed {
    grant_t      g;
    logic [4:0]  s;
    logic [31:0] it;
    logic [31:0] od;
    logic        fs;
  } grant_rec_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    logic        op;
    logic [4:0]  who;
    logic        typed;
    grant_rec_t  want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic        opcode;
  logic [4:0]  worker;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  grant;
  logic [4:0]  slot;
  logic [31:0] iteration;
  logic [31:0] ordered_done;
  logic        finishes_settled;

  // dispatcher state as the testbench sees it
  logic [31:0] cfg_iters;
  logic [4:0]  cfg_workers;
  logic [5:0]  cfg_slots;
  phase_t      slot_ph [MAX_SLOTS];
  logic [31:0] slot_it [MAX_SLOTS];
  logic [5:0]  held [MAX_WORKERS];
  logic [31:0] n_started, n_ordered, n_finished;
  logic [4:0]  p_start, p_order, p_finish;
  logic [5:0]  order_owner;

  grant_rec_t  pending_grants [$];
  logic        typed_on;
  grant_rec_t  typed_want;
  int          mismatches;
  int          cycle_cnt;

  ordered_stage_task_dispatcher_top #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAX_WORKERS(MAX_WORKERS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .worker(worker),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .grant(grant),
    .slot(slot),
    .iteration(iteration),
    .ordered_done(ordered_done),
    .finishes_settled(finishes_settled)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic ring_idle();
    int i;
    for (i = 0; i < MAX_SLOTS; i++)
      if (slot_ph[i] != PH_READY_START) return 1'b0;
    return 1'b1;
  endfunction

  // One request against the local copy of the dispatcher; returns the grant it should give.
  function automatic grant_rec_t dispatch_step(input logic op, input logic [4:0] w);
    grant_rec_t  r;
    logic [31:0] lim;
    logic [31:0] ns;
    logic [5:0]  mine;
    logic        took;
    logic        busy;
    int          i;
    r = '0;
    r.g = G_REJECT;
    took = 1'b0;
    lim = cfg_iters;
    ns = (cfg_slots == 6'd0) ? 32'd1 :
         (cfg_slots > MAX_SLOTS) ? 32'(MAX_SLOTS) : 32'(cfg_slots);
    if (op == OP_ABORT) begin
      n_started = lim;
      n_ordered = lim;
      n_finished = lim;
      order_owner = OWNER_DEAD;
    end else if (w < cfg_workers && w < MAX_WORKERS) begin
      mine = held[w];
      // retire whatever this worker held before
      if (mine < MAX_SLOTS) begin
        if (slot_ph[mine] == PH_FINISHING) slot_ph[mine] = PH_READY_START;
        else slot_ph[mine] = phase_t'(slot_ph[mine] + 3'd1);
      end
      if (order_owner == {1'b0, w}) order_owner = OWNER_NONE;

      if (order_owner == OWNER_NONE && n_ordered < lim &&
          slot_ph[p_order] == PH_READY_ORDER) begin
        r.s = p_order;
        order_owner = {1'b0, w};
        slot_ph[p_order] = PH_ORDERING;
        n_ordered = n_ordered + 32'd1;
        p_order = 5'(n_ordered % ns);
        r.g = G_ORDERED;
        took = 1'b1;
      end else if (n_finished < lim && slot_ph[p_finish] == PH_READY_FINISH) begin
        r.s = p_finish;
        slot_ph[p_finish] = PH_FINISHING;
        n_finished = n_finished + 32'd1;
        p_finish = 5'(n_finished % ns);
        r.g = G_FINISH;
        took = 1'b1;
      end else if (n_started < lim && slot_ph[p_start] == PH_READY_START) begin
        r.s = p_start;
        slot_it[p_start] = n_started;
        slot_ph[p_start] = PH_STARTING;
        n_started = n_started + 32'd1;
        p_start = 5'(n_started % ns);
        r.g = G_START;
        took = 1'b1;
      end else if (n_finished < lim) begin
        r.g = G_WAIT;
      end else begin
        r.g = G_NONE;
      end

      if (took) begin
        held[w] = {1'b0, r.s};
        r.it = slot_it[r.s];
      end else begin
        held[w] = HOLD_NONE;
        r.s = '0;
      end
    end
    busy = 1'b0;
    for (i = 0; i < ns; i++)
      if (slot_ph[i] == PH_FINISHING) busy = 1'b1;
    r.od = n_ordered;
    r.fs = (n_ordered != 32'd0) && (n_finished == n_ordered - 32'd1) && !busy;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic op, input logic [4:0] who);
    plan_row_t p;
    p = '0;
    p.op = op;
    p.who = who;
    return p;
  endfunction

  function automatic plan_row_t typed_row(input logic op, input logic [4:0] who,
                                          input grant_t g, input logic [4:0] s,
                                          input logic [31:0] it, input logic [31:0] od,
                                          input logic fs);
    plan_row_t p;
    p = req_row(op, who);
    p.typed = 1'b1;
    p.want.g = g;
    p.want.s = s;
    p.want.it = it;
    p.want.od = od;
    p.want.fs = fs;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = val;
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // All driving tasks start and end at a falling edge.
  task automatic issue(input logic op, input logic [4:0] who, input logic typed,
                       input grant_rec_t want, input logic may_idle);
    int unsigned g;
    g = may_idle ? pause_len() : 0;
    if (g != 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    typed_on = typed;
    typed_want = want;
    req_valid <= 1'b1;
    opcode <= op;
    worker <= who;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // result side stall: free stretches of varying length, short and long holds
  initial begin
    int unsigned stretch, hold;
    res_stall = 1'b0;
    forever begin
      stretch = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      hold = pause_len();
      repeat (stretch) @(negedge clk) res_stall <= 1'b0;
      repeat (hold) @(negedge clk) res_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ITERATIONS: cfg_iters = cfg_data;
        CFG_WORKERS:    cfg_workers = cfg_data[4:0];
        CFG_SLOTS:      cfg_slots = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : take_request
    grant_rec_t e;
    if (!rst && req_valid && !req_stall) begin
      e = dispatch_step(opcode, worker);
      if (typed_on) e = typed_want;
      pending_grants.push_back(e);
    end
  end

  always @(posedge clk) begin : check_grant
    grant_rec_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch("unexpected result, grant", 32'(grant), 32'd0);
      end else begin
        e = pending_grants.pop_front();
        if (grant !== e.g) flag_mismatch("grant", 32'(grant), 32'(e.g));
        if (slot !== e.s) flag_mismatch("slot", 32'(slot), 32'(e.s));
        if (iteration !== e.it) flag_mismatch("iteration", iteration, e.it);
        if (ordered_done !== e.od) flag_mismatch("ordered_done", ordered_done, e.od);
        if (finishes_settled !== e.fs)
          flag_mismatch("finishes_settled", 32'(finishes_settled), 32'(e.fs));
      end
    end
  end

  initial begin
    plan_row_t   script [$];
    int          i, ph, sent, top, slot_pick;
    logic        calm;
    logic        op;
    logic [4:0]  who;
    logic [31:0] val;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    opcode = OP_REQUEST;
    worker = '0;
    typed_on = 1'b0;
    typed_want = '0;
    mismatches = 0;
    cycle_cnt = 0;

    cfg_iters = 32'd1;
    cfg_workers = 5'd2;
    cfg_slots = 6'd3;
    for (i = 0; i < MAX_SLOTS; i++) begin
      slot_ph[i] = PH_READY_START;
      slot_it[i] = '0;
    end
    for (i = 0; i < MAX_WORKERS; i++) held[i] = HOLD_NONE;
    n_started = '0;
    n_ordered = '0;
    n_finished = '0;
    p_start = '0;
    p_order = '0;
    p_finish = '0;
    order_owner = OWNER_NONE;

    // one iteration through all three phases, then none left
    script.push_back(cfg_row(CFG_ITERATIONS, 32'd1));
    script.push_back(typed_row(OP_REQUEST, 5'd0, G_START, 5'd0, 32'd0, 32'd0, 1'b0));
    script.push_back(typed_row(OP_REQUEST, 5'd2, G_REJECT, 5'd0, 32'd0, 32'd0, 1'b0));
    script.push_back(typed_row(OP_REQUEST, 5'd31, G_REJECT, 5'd0, 32'd0, 32'd0, 1'b0));
    script.push_back(typed_row(OP_REQUEST, 5'd1, G_WAIT, 5'd0, 32'd0, 32'd0, 1'b0));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(req_row(OP_REQUEST, 5'd1));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(typed_row(OP_REQUEST, 5'd0, G_NONE, 5'd0, 32'd0, 32'd1, 1'b0));
    // repeated request after none left must not advance anything
    script.push_back(typed_row(OP_REQUEST, 5'd0, G_NONE, 5'd0, 32'd0, 32'd1, 1'b0));
    // zero slots acts as one; start pointer keeps its old value until it next moves
    script.push_back(cfg_row(CFG_ITERATIONS, 32'd4));
    script.push_back(cfg_row(CFG_WORKERS, 32'd31));
    script.push_back(cfg_row(CFG_SLOTS, 32'd0));
    script.push_back(typed_row(OP_REQUEST, 5'd16, G_REJECT, 5'd0, 32'd0, 32'd1, 1'b0));
    script.push_back(typed_row(OP_REQUEST, 5'd30, G_REJECT, 5'd0, 32'd0, 32'd1, 1'b0));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(req_row(OP_REQUEST, 5'd0));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd15));
    script.push_back(req_row(OP_REQUEST, 5'd15));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        issue(script[i].op, script[i].who, script[i].typed, script[i].want, 1'b1);
      end
    end

    slot_pick = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      // ring size only changes when no slot is in flight
      if (ring_idle() && (slot_pick < 6 || $urandom_range(0, 2) == 0)) begin
        case (slot_pick)
          0: val = 32'd32;
          1: val = 32'd1;
          2: val = 32'd63;
          3: val = 32'd2;
          4: val = 32'd0;
          5: val = 32'd5;
          default: val = $urandom_range(1, 40);
        endcase
        slot_pick++;
        write_reg(CFG_SLOTS, val);
      end
      case (ph)
        0: val = 32'd16;
        1: val = 32'd2;
        2: val = 32'd7;
        3: val = 32'd31;
        4: val = 32'd16;
        5: val = 32'd1;
        6: val = 32'd0;
        7: val = 32'd3;
        9: val = 32'd2;
        10: val = 32'd16;
        default: val = $urandom_range(2, 16);
      endcase
      write_reg(CFG_WORKERS, val);
      if (ph == 4) write_reg(CFG_ITERATIONS, 32'hFFFF_FFFF);
      else write_reg(CFG_ITERATIONS, n_started + 32'($urandom_range(1, 12)));

      calm = ($urandom_range(0, 3) == 0);
      top = (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : int'(cfg_workers);
      sent = 0;
      do begin
        if (top > 0 && $urandom_range(0, 99) < 88) who = 5'($urandom_range(0, top - 1));
        else who = 5'($urandom_range(0, 31));
        op = OP_REQUEST;
        if (ph >= PHASES - 2 && ($urandom_range(0, 24) == 0 || (ph == PHASES - 1 && sent == 0)))
          op = OP_ABORT;
        issue(op, who, 1'b0, '0, !calm);
        sent++;
      end while (sent < PHASE_CAP && !(ring_idle() && n_finished == cfg_iters));
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
